// File: hdl/assert_macros.svh
// Assertion helpers for the mipmap pyramid block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/mbfp_pkg.sv
package mbfp_pkg;

   localparam int MAX_LOG_SIZE     = 10;
   localparam int LINE_STORE_DEPTH = 1024;

   localparam int PIX_W  = 32;
   localparam int SUM_W  = 36;
   localparam int LOG_W  = 4;
   localparam int POS_W  = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_LOG2  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_LOG2 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIP_ENABLE  = 2'd2;

   typedef struct packed {
      logic [LOG_W-1:0] level;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic [PIX_W-1:0] color;
      logic             run_end;
   } rsp_beat_type;

   // Widen each 8-bit channel into a 9-bit lane
   function automatic logic [SUM_W-1:0] spread_lanes(input logic [PIX_W-1:0] p);
      logic [SUM_W-1:0] s;
      s = '0;
      for (int k = 0; k < 4; k++) begin
         s[9*k +: 9] = {1'b0, p[8*k +: 8]};
      end
      return s;
   endfunction

   // Lane-wise add of two lane vectors
   function automatic logic [SUM_W-1:0] add_lanes(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = '0;
      for (int k = 0; k < 4; k++) begin
         s[9*k +: 9] = a[9*k +: 9] + b[9*k +: 9];
      end
      return s;
   endfunction

   // Per-lane (a + b) >> 2, truncated to 8 bits
   function automatic logic [PIX_W-1:0] finish_avg(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
      logic [PIX_W-1:0] res;
      logic [9:0]       t;
      res = '0;
      for (int k = 0; k < 4; k++) begin
         t = {1'b0, a[9*k +: 9]} + {1'b0, b[9*k +: 9]};
         res[8*k +: 8] = t[9:2];
      end
      return res;
   endfunction

endpackage

// File: hdl/mbfp_req_if.sv
interface mbfp_req_if;
   logic                       valid;
   logic                       ready;
   logic [mbfp_pkg::PIX_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// File: hdl/mbfp_rsp_if.sv
interface mbfp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mbfp_pkg::LOG_W-1:0] level;
   logic [mbfp_pkg::POS_W-1:0] column;
   logic [mbfp_pkg::POS_W-1:0] row;
   logic [mbfp_pkg::PIX_W-1:0] color;
   logic                       run_end;

   modport source (output valid, output level, output column, output row,
                   output color, output run_end, input ready);
   modport sink   (input valid, input level, input column, input row,
                   input color, input run_end, output ready);
endinterface

// File: hdl/mbfp_ram.sv
module mbfp_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/mipmap_box_filter_pyramid_top.sv
// Streaming 2x2 box-filter mip chain generator. Each accepted pixel (raster
// order) is echoed as level 0 and, when mipmapping is on, walks up the levels
// one per step: a level step reads the line store (ST_READ), then emits
// (ST_EMIT). After a pixel's final beat the sequencer waits (ST_WAIT) until
// that beat is taken, so no new pixel is accepted while one is in flight. A
// pixel climbs at most to level top, max(width_log2, height_log2) saturated
// at MAX_LOG_SIZE; a step waits in ST_READ until the previous beat is taken.
// The line store is a single-port-read RAM of LINE_STORE_DEPTH 36-bit entries
// shared by all levels; its registered read sets the ST_READ step. Each result
// beat is held in an output register; ready returns once the last beat of the
// run has been taken. Any register write restarts the image at position zero.
`include "assert_macros.svh"

module mipmap_box_filter_pyramid_top #(
   parameter int MAX_LOG_SIZE     = mbfp_pkg::MAX_LOG_SIZE,
   parameter int LINE_STORE_DEPTH = mbfp_pkg::LINE_STORE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   mbfp_req_if.sink                        req,
   mbfp_rsp_if.source                      rsp,
   input  logic                            csr_write,
   input  logic [mbfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbfp_pkg::CSR_DATA_W-1:0] csr_data
);
   localparam int LEVELS = MAX_LOG_SIZE + 1;
   localparam int LV_W   = $clog2(LEVELS + 1);
   localparam int ADDR_W = $clog2(LINE_STORE_DEPTH);
   localparam int LOG_W  = mbfp_pkg::LOG_W;
   localparam int POS_W  = mbfp_pkg::POS_W;
   localparam int PIX_W  = mbfp_pkg::PIX_W;
   localparam int SUM_W  = mbfp_pkg::SUM_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   // Configuration
   logic [LOG_W-1:0] width_log2_ff, height_log2_ff;
   logic             mip_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= LOG_W'(8);
         height_log2_ff <= LOG_W'(8);
         mip_enable_ff  <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            mbfp_pkg::CSR_WIDTH_LOG2:  width_log2_ff  <= csr_data;
            mbfp_pkg::CSR_HEIGHT_LOG2: height_log2_ff <= csr_data;
            mbfp_pkg::CSR_MIP_ENABLE:  mip_enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   wire csr_hit = csr_write && (csr_index == mbfp_pkg::CSR_WIDTH_LOG2 ||
                  csr_index == mbfp_pkg::CSR_HEIGHT_LOG2 ||
                  csr_index == mbfp_pkg::CSR_MIP_ENABLE);

   // Saturated sizes and top level
   logic [LOG_W-1:0] wl, hl, top;
   always_comb begin
      wl  = (width_log2_ff  > LOG_W'(MAX_LOG_SIZE)) ? LOG_W'(MAX_LOG_SIZE) : width_log2_ff;
      hl  = (height_log2_ff > LOG_W'(MAX_LOG_SIZE)) ? LOG_W'(MAX_LOG_SIZE) : height_log2_ff;
      top = (wl > hl) ? wl : hl;
   end

   // Sequencer state
   state_type          state_ff, state_in;
   logic [LV_W-1:0]    lv_ff, lv_in;
   logic [PIX_W-1:0]   cur_ff, cur_in;
   logic [POS_W-1:0]   col_ff [LEVELS];
   logic [POS_W-1:0]   row_ff [LEVELS];
   logic [PIX_W-1:0]   hold_ff [LEVELS];
   mbfp_pkg::rsp_beat_type beat_ff, beat_in;
   logic               beat_valid_ff, beat_valid_in;

   // Current level geometry
   logic [LOG_W-1:0] lv4, wsh, hsh;
   logic [POS_W:0]   w, h;
   logic [POS_W-1:0] c, r;
   logic             w_one, h_one, last_col, last_row, stop_mip;
   logic [ADDR_W-1:0] addr;

   always_comb begin
      lv4 = LOG_W'(lv_ff);
      wsh = (wl > lv4) ? wl - lv4 : '0;
      hsh = (hl > lv4) ? hl - lv4 : '0;
      w   = (POS_W+1)'(1) << wsh;
      h   = (POS_W+1)'(1) << hsh;
      c   = col_ff[lv_ff[$clog2(LEVELS)-1:0]];
      r   = row_ff[lv_ff[$clog2(LEVELS)-1:0]];
      w_one = (wsh == '0);
      h_one = (hsh == '0);
      last_col = ((POS_W+1)'(c) + 1'b1) >= w;
      last_row = ((POS_W+1)'(r) + 1'b1) >= h;
      stop_mip = !mip_enable_ff || (lv4 >= top);
      addr = ADDR_W'(LINE_STORE_DEPTH - (LINE_STORE_DEPTH >> lv_ff))
             + ADDR_W'(c >> 1);
   end

   // Per-level decisions at emit time
   logic             go_up, hold_wr, pair_sel;
   logic [SUM_W-1:0] pair_now;
   logic [PIX_W-1:0] hold_cur;
   always_comb begin
      hold_cur = hold_ff[lv_ff[$clog2(LEVELS)-1:0]];
      pair_now = w_one ? mbfp_pkg::add_lanes(mbfp_pkg::spread_lanes(cur_ff),
                                             mbfp_pkg::spread_lanes(cur_ff))
                       : mbfp_pkg::add_lanes(mbfp_pkg::spread_lanes(hold_cur),
                                             mbfp_pkg::spread_lanes(cur_ff));
      hold_wr  = !stop_mip && !w_one && !c[0];
      pair_sel = !stop_mip && (w_one || c[0]);
      go_up    = pair_sel && (h_one || r[0]);
   end

   // Shared line store
   logic             ram_we;
   logic [SUM_W-1:0] ram_q;

   mbfp_ram #(.WIDTH(SUM_W), .DEPTH(LINE_STORE_DEPTH)) u_line (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(addr),
      .wr_data(pair_now),
      .rd_addr(addr),
      .rd_data(ram_q)
   );

   wire req_fire = req.valid && req.ready;
   wire rsp_fire = rsp.valid && rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && !csr_hit;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      lv_in         = lv_ff;
      cur_in        = cur_ff;
      beat_in       = beat_ff;
      beat_valid_in = beat_valid_ff;
      ram_we        = 1'b0;
      if (rsp_fire) begin
         beat_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               lv_in    = '0;
               cur_in   = req.pixel;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // line store read is in flight; wait for output slot
            if (!beat_valid_ff || rsp_fire) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            beat_in.level   = lv4;
            beat_in.column  = c;
            beat_in.row     = r;
            beat_in.color   = cur_ff;
            beat_in.run_end = !go_up;
            beat_valid_in   = 1'b1;
            // even-row pair sum goes to the line store while positions are current
            ram_we          = pair_sel && !h_one && !r[0];
            if (go_up) begin
               cur_in   = h_one ? mbfp_pkg::finish_avg(pair_now, pair_now)
                                : mbfp_pkg::finish_avg(ram_q, pair_now);
               lv_in    = lv_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // wait for the final beat
            if (!beat_valid_ff || rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lv_ff         <= '0;
         beat_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lv_ff         <= (state_ff == ST_WAIT) ? lv_ff : lv_in;
         beat_valid_ff <= beat_valid_in;
      end
      cur_ff  <= cur_in;
      beat_ff <= beat_in;
   end

   // Level positions and even-column hold
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         for (int i = 0; i < LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else if (state_ff == ST_EMIT) begin
         col_ff[lv_ff[$clog2(LEVELS)-1:0]] <= last_col ? '0 : c + 1'b1;
         row_ff[lv_ff[$clog2(LEVELS)-1:0]] <= last_col ? (last_row ? '0 : r + 1'b1) : r;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && hold_wr) begin
         hold_ff[lv_ff[$clog2(LEVELS)-1:0]] <= cur_ff;
      end
   end

   assign rsp.valid   = beat_valid_ff;
   assign rsp.level   = beat_ff.level;
   assign rsp.column  = beat_ff.column;
   assign rsp.row     = beat_ff.row;
   assign rsp.color   = beat_ff.color;
   assign rsp.run_end = beat_ff.run_end;

   `ASSERT_IMP(a_no_accept_busy, clock, reset, req_fire, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_accept_reads, clock, reset, req_fire, state_ff == ST_READ && lv_ff == '0)
   `ASSERT_IMP(a_level_bound, clock, reset, state_ff == ST_EMIT, lv4 <= top)
   `ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
endmodule

// File: sim/mipmap_box_filter_pyramid_top_test.sv
module mipmap_box_filter_pyramid_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mbfp_pkg::*;

   localparam int LEVEL_COUNT = MAX_LOG_SIZE + 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 2 * LEVEL_COUNT + 10;
   localparam int RANDOM_PIXELS = 187;

   // Mip chain predictor plus the queue of beats it expects
   class pyramid_scoreboard;
      logic [LOG_W-1:0]  width_log2;
      logic [LOG_W-1:0]  height_log2;
      logic              mip_enable;
      int unsigned       lvl_col [LEVEL_COUNT];
      int unsigned       lvl_row [LEVEL_COUNT];
      logic [PIX_W-1:0]  col_hold [LEVEL_COUNT];
      logic [SUM_W-1:0]  row_sums [LINE_STORE_DEPTH];
      rsp_beat_type      awaited [$];
      int                failures;
      int                beats_seen;
      int                deepest;

      function new();
         width_log2  = 4'd8;
         height_log2 = 4'd8;
         mip_enable  = 1'b1;
         failures    = 0;
         beats_seen  = 0;
         deepest     = 0;
         restart();
      endfunction

      function void restart();
         foreach (lvl_col[i]) begin
            lvl_col[i] = 0;
            lvl_row[i] = 0;
         end
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_WIDTH_LOG2:  width_log2  = val;
            CSR_HEIGHT_LOG2: height_log2 = val;
            CSR_MIP_ENABLE:  mip_enable  = val[0];
            default: return;
         endcase
         restart();
      endfunction

      function logic [SUM_W-1:0] widen(logic [PIX_W-1:0] p);
         logic [SUM_W-1:0] s;
         s = '0;
         for (int k = 0; k < 4; k++) s[9*k +: 9] = {1'b0, p[8*k +: 8]};
         return s;
      endfunction

      // per-channel (a + b) >> 2 over the 9-bit lanes
      function logic [PIX_W-1:0] quarter(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
         logic [PIX_W-1:0] res;
         logic [9:0]       t;
         for (int k = 0; k < 4; k++) begin
            t = {1'b0, a[9*k +: 9]} + {1'b0, b[9*k +: 9]};
            res[8*k +: 8] = t[9:2];
         end
         return res;
      endfunction

      // Walk one pixel up the chain, queueing every beat it produces
      function void note_pixel(logic [PIX_W-1:0] pixel);
         int unsigned  wl, hl, top, lv, w, h, c, r, addr;
         logic [PIX_W-1:0] cur;
         logic [SUM_W-1:0] pair;
         rsp_beat_type     b;
         wl  = (width_log2 > MAX_LOG_SIZE) ? MAX_LOG_SIZE : width_log2;
         hl  = (height_log2 > MAX_LOG_SIZE) ? MAX_LOG_SIZE : height_log2;
         top = (wl > hl) ? wl : hl;
         cur = pixel;
         lv  = 0;
         forever begin
            w = 1 << ((wl > lv) ? wl - lv : 0);
            h = 1 << ((hl > lv) ? hl - lv : 0);
            c = lvl_col[lv] % w;
            r = lvl_row[lv] % h;
            b.level   = LOG_W'(lv);
            b.column  = POS_W'(c);
            b.row     = POS_W'(r);
            b.color   = cur;
            b.run_end = 1'b0;
            awaited.push_back(b);
            if (lv > deepest) deepest = lv;
            if (c + 1 >= w) begin
               lvl_col[lv] = 0;
               lvl_row[lv] = (r + 1 >= h) ? 0 : r + 1;
            end else begin
               lvl_col[lv] = c + 1;
            end
            if (!mip_enable || lv >= top) break;
            if (w == 1) begin
               pair = widen(cur) + widen(cur);
            end else if (c[0] == 1'b0) begin
               col_hold[lv] = cur;
               break;
            end else begin
               pair = widen(col_hold[lv]) + widen(cur);
            end
            if (h == 1) begin
               cur = quarter(pair, pair);
            end else begin
               addr = (LINE_STORE_DEPTH - (LINE_STORE_DEPTH >> lv) + (c >> 1))
                      % LINE_STORE_DEPTH;
               if (r[0] == 1'b0) begin
                  row_sums[addr] = pair;
                  break;
               end
               cur = quarter(row_sums[addr], pair);
            end
            lv++;
         end
         awaited[$].run_end = 1'b1;
      endfunction

      function void check_beat(rsp_beat_type got);
         rsp_beat_type exp;
         beats_seen++;
         if (awaited.size() == 0) begin
            $error("unexpected beat: level %0d column %0d row %0d color %h",
                   got.level, got.column, got.row, got.color);
            failures++;
            return;
         end
         exp = awaited.pop_front();
         if (got.level !== exp.level) begin
            $error("level: expected %0d, got %0d", exp.level, got.level);
            failures++;
         end
         if (got.column !== exp.column) begin
            $error("column: expected %0d, got %0d", exp.column, got.column);
            failures++;
         end
         if (got.row !== exp.row) begin
            $error("row: expected %0d, got %0d", exp.row, got.row);
            failures++;
         end
         if (got.color !== exp.color) begin
            $error("color: expected %h, got %h", exp.color, got.color);
            failures++;
         end
         if (got.run_end !== exp.run_end) begin
            $error("run_end: expected %0b, got %0b", exp.run_end, got.run_end);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   mbfp_req_if req_ch ();
   mbfp_rsp_if rsp_ch ();

   pyramid_scoreboard sb;
   int  cycles;
   int  pixels_sent;
   bit  tx_idle;
   bit  rx_idle;

   mipmap_box_filter_pyramid_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random stalls, check each beat taken
   initial begin : rsp_side
      rsp_beat_type got;
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = rx_idle ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.level   = rsp_ch.level;
         got.column  = rsp_ch.column;
         got.row     = rsp_ch.row;
         got.color   = rsp_ch.color;
         got.run_end = rsp_ch.run_end;
         sb.check_beat(got);
      end
   end

   task automatic send_pixel(logic [PIX_W-1:0] p);
      int gap;
      gap = tx_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= p;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_pixel(p);
      pixels_sent++;
   endtask

   // Hold off the input until every queued beat has been taken
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.awaited.size() > 0) @(posedge clock);
   endtask

   // Quiesce, then program all three registers back to back
   task automatic program_image(int wl, int hl, bit en);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_WIDTH_LOG2;
      csr_data  <= CSR_DATA_W'(wl);
      @(posedge clock);
      sb.set_reg(CSR_WIDTH_LOG2, CSR_DATA_W'(wl));
      csr_index <= CSR_HEIGHT_LOG2;
      csr_data  <= CSR_DATA_W'(hl);
      @(posedge clock);
      sb.set_reg(CSR_HEIGHT_LOG2, CSR_DATA_W'(hl));
      csr_index <= CSR_MIP_ENABLE;
      csr_data  <= CSR_DATA_W'(en);
      @(posedge clock);
      sb.set_reg(CSR_MIP_ENABLE, CSR_DATA_W'(en));
      csr_write <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      int wl, hl, npix, remaining, phases;
      bit en;
      sb = new();
      cycles = 0;
      pixels_sent = 0;
      phases = 0;
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_WIDTH_LOG2;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 1x1 image: the base pixel is also the top
      program_image(0, 0, 1'b1);
      send_pixel('1);
      send_pixel('0);
      // one-row level: pairs averaged against themselves
      tx_idle = 1'b1;
      program_image(2, 0, 1'b1);
      send_pixel('1); send_pixel('1); send_pixel(32'h0302_0100); send_pixel('0);
      // one-column level: each pixel paired with itself
      rx_idle = 1'b1;
      program_image(0, 2, 1'b1);
      send_pixel('1); send_pixel(32'h8040_2010); send_pixel('0); send_pixel('1);
      // chain off, with a full drain partway through
      program_image(1, 1, 1'b0);
      send_pixel('1); send_pixel('0);
      drain();
      send_pixel(32'h5555_5555); send_pixel(32'haaaa_aaaa);
      // oversize sizes saturate
      program_image(15, 15, 1'b1);
      send_pixel('1); send_pixel('1); send_pixel('0);
      // square image with a rollover into a second image
      program_image(1, 1, 1'b1);
      repeat (6) send_pixel(rand_pixel());

      // Random images, mostly small and completed, a few large and partial
      remaining = RANDOM_PIXELS;
      while (remaining > 0) begin
         if ($urandom_range(0, 5) == 0) begin
            wl = $urandom_range(5, 15);
            hl = $urandom_range(0, 15);
         end else begin
            wl = $urandom_range(0, 4);
            hl = $urandom_range(0, 4);
         end
         en = ($urandom_range(0, 3) != 0);
         npix = (wl + hl <= 6) ? (1 << (wl + hl)) * $urandom_range(1, 2)
                               : $urandom_range(8, 64);
         if (npix > remaining) npix = remaining;
         tx_idle = ($urandom_range(0, 2) != 0);
         rx_idle = ($urandom_range(0, 2) != 0);
         program_image(wl, hl, en);
         repeat (npix) send_pixel(rand_pixel());
         remaining -= npix;
         phases++;
      end

      // Wind down
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.awaited.size() > 0) begin
         $error("%0d expected beats never arrived", sb.awaited.size());
         sb.failures++;
      end
      $display("Sent %0d pixels over %0d random images plus directed cases.",
               pixels_sent, phases);
      $display("Checked %0d result beats, deepest mip level reached %0d.",
               sb.beats_seen, sb.deepest);
      if (sb.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
